// File: sv/mrt_pkg.sv
package mrt_pkg;
   localparam int TableEntries = 32;
   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = $clog2(TableEntries + 1);
   localparam int IdW = 16;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_REMOVE_ALL = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [IdW-1:0] producer;
      logic [IdW-1:0] consumer;
      logic [IdW-1:0] proc_addr;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } slot_type;

   typedef struct packed {
      logic           active;
      cmd_type        cmd;
      logic [IdW-1:0] producer;
      logic [IdW-1:0] consumer;
      logic [IdW-1:0] proc_addr;
      logic           done;
   } token_type;
endpackage

// File: sv/mrt_cell.sv
module mrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  mrt_pkg::token_type tok_in,
   output mrt_pkg::token_type tok_out,
   output logic              hit,
   output mrt_pkg::entry_type hit_data
);
   import mrt_pkg::*;

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;
   token_type tok_ff, tok_in_n;
   logic      hit_ff, hit_in;
   entry_type hit_data_ff;
   logic      prod_eq, pair_eq;

   always_comb begin
      prod_eq = valid_ff && (data_ff.producer == tok_in.producer);
      pair_eq = prod_eq && (data_ff.consumer == tok_in.consumer);
      valid_in = valid_ff;
      data_in = data_ff;
      tok_in_n = tok_in;
      hit_in = 1'b0;
      if (tok_in.active && !tok_in.done) begin
         case (tok_in.cmd)
            CMD_INSERT: begin
               if (!valid_ff) begin
                  valid_in = 1'b1;
                  data_in = '{tok_in.producer, tok_in.consumer, tok_in.proc_addr};
                  tok_in_n.done = 1'b1;
               end
            end
            CMD_SEARCH: begin
               if (pair_eq) tok_in_n.done = 1'b1;
            end
            CMD_REMOVE: begin
               if (pair_eq) begin
                  valid_in = 1'b0;
                  hit_in = 1'b1;
                  tok_in_n.done = 1'b1;
               end
            end
            CMD_REMOVE_ALL: begin
               if (prod_eq) begin
                  valid_in = 1'b0;
                  hit_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff.active <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff <= tok_in_n;
         hit_ff <= hit_in;
      end
      data_ff <= data_in;
      hit_data_ff <= data_ff;
   end

   assign tok_out = tok_ff;
   assign hit = hit_ff;
   assign hit_data = hit_data_ff;
endmodule

// File: sv/message_request_table.sv
// Timing: an item walks one cell per cycle; its final result appears once the token has
// passed the last cell (remove-all results stream as the token passes matching cells).
// Only one item is in flight at a time: start is ignored while busy.
// Reset: synchronous, clears all valid marks at once; the table is empty after reset.
// Results are strobed for one cycle; the receiver cannot stall.
module message_request_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_producer_task,
   input  logic [15:0] req_consumer_task,
   input  logic [15:0] req_requester_proc,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [15:0] rsp_entry_producer,
   output logic [15:0] rsp_entry_consumer,
   output logic [15:0] rsp_entry_proc,
   output logic        rsp_last
);
   import mrt_pkg::*;

   token_type tok [TableEntries+1];
   logic      hit [TableEntries];
   entry_type hd  [TableEntries];

   logic           busy_ff;
   logic           any_ff, any_in;
   logic           pend_ff, pend_in;
   entry_type      pend_data_ff, pend_data_in;
   logic           v_ff, ok_ff, last_ff;
   entry_type      out_ff;
   logic           emit_v, emit_ok, emit_last;
   entry_type      emit_d;
   token_type      fin;
   token_type      last_tok_ff;

   always_comb begin
      tok[0].active = start && !busy_ff;
      tok[0].cmd = cmd_type'(req_cmd);
      tok[0].producer = req_producer_task;
      tok[0].consumer = req_consumer_task;
      tok[0].proc_addr = req_requester_proc;
      tok[0].done = 1'b0;
   end

   for (genvar g = 0; g < TableEntries; g++) begin : g_cell
      mrt_cell u_cell (
         .clock(clock), .reset(reset), .tok_in(tok[g]), .tok_out(tok[g+1]),
         .hit(hit[g]), .hit_data(hd[g])
      );
   end

   // hits of the token at cell g surface together with tok[g+1]; collect by position
   logic [IdxW:0] pos_ff;
   logic          cur_hit;
   entry_type     cur_d;

   always_comb begin
      cur_hit = 1'b0;
      cur_d = '0;
      for (int k = 0; k < TableEntries; k++) begin
         if (hit[k]) begin
            cur_hit = 1'b1;
            cur_d = hd[k];
         end
      end
      fin = last_tok_ff;
      emit_v = 1'b0;
      emit_ok = 1'b0;
      emit_last = 1'b0;
      emit_d = '0;
      any_in = any_ff;
      pend_in = pend_ff;
      pend_data_in = pend_data_ff;
      if (cur_hit) begin
         if (pend_ff) begin
            emit_v = 1'b1;
            emit_ok = 1'b1;
            emit_d = pend_data_ff;
         end
         pend_in = 1'b1;
         pend_data_in = cur_d;
         any_in = 1'b1;
      end
      if (pos_ff == IdxW'(0) + (IdxW+1)'(TableEntries) && busy_ff) begin
         if (fin.cmd == CMD_REMOVE_ALL || fin.cmd == CMD_REMOVE) begin
            emit_v = 1'b1;
            emit_ok = pend_in;
            emit_d = pend_in ? pend_data_in : '0;
            emit_last = 1'b1;
         end else begin
            emit_v = 1'b1;
            emit_ok = fin.done;
            emit_last = 1'b1;
         end
         pend_in = 1'b0;
         any_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= '0;
         pend_ff <= 1'b0;
         any_ff <= 1'b0;
         v_ff <= 1'b0;
      end else begin
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            pos_ff <= '0;
         end else if (busy_ff) begin
            if (pos_ff == (IdxW+1)'(TableEntries)) busy_ff <= 1'b0;
            else pos_ff <= pos_ff + 1'b1;
         end
         pend_ff <= pend_in;
         any_ff <= any_in;
         v_ff <= emit_v;
      end
      pend_data_ff <= pend_data_in;
      ok_ff <= emit_ok;
      last_ff <= emit_last;
      out_ff <= emit_d;
      last_tok_ff <= tok[TableEntries];
   end

   assign busy = busy_ff;
   assign rsp_valid = v_ff;
   assign rsp_ok = ok_ff;
   assign rsp_last = last_ff;
   assign rsp_entry_producer = out_ff.producer;
   assign rsp_entry_consumer = out_ff.consumer;
   assign rsp_entry_proc = out_ff.proc_addr;

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_last) else $error("failure result not last");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_entry_producer == '0) else $error("nonzero fields");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !$past(busy_ff) |-> !cur_hit) else $error("hit while idle");
   a_any: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> any_ff) else $error("pending without match");
   a_tok: assert property (@(posedge clock) disable iff (reset)
      last_tok_ff.active |-> busy_ff || $past(busy_ff)) else $error("stray token");
endmodule

// File: tb/sv/request_table_checker.sv
module request_table_checker
   import mrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_producer_task,
   input  logic [15:0] req_consumer_task,
   input  logic [15:0] req_requester_proc,
   input  logic        rsp_valid,
   input  logic        rsp_ok,
   input  logic [15:0] rsp_entry_producer,
   input  logic [15:0] rsp_entry_consumer,
   input  logic [15:0] rsp_entry_proc,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_count
);
   typedef struct packed {
      logic           ok;
      logic [IdW-1:0] producer;
      logic [IdW-1:0] consumer;
      logic [IdW-1:0] proc_addr;
      logic           last;
   } outcome_type;

   slot_type    table_copy[TableEntries];
   outcome_type outcome_q[$];

   initial begin
      fail_count = 0;
      rsp_count = 0;
   end

   assign pending_count = outcome_q.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic predict_table(input cmd_type cmd, input logic [IdW-1:0] prod,
                                input logic [IdW-1:0] cons, input logic [IdW-1:0] proc_addr);
      int n;
      logic hit;
      n = 0;
      hit = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            for (int i = 0; i < TableEntries; i++)
               if (!hit && !table_copy[i].valid) begin
                  table_copy[i] = '{1'b1, '{prod, cons, proc_addr}};
                  hit = 1'b1;
               end
            outcome_q.push_back('{hit, 16'd0, 16'd0, 16'd0, 1'b1});
         end
         CMD_SEARCH: begin
            for (int i = 0; i < TableEntries; i++)
               if (table_copy[i].valid && table_copy[i].data.producer == prod &&
                   table_copy[i].data.consumer == cons)
                  hit = 1'b1;
            outcome_q.push_back('{hit, 16'd0, 16'd0, 16'd0, 1'b1});
         end
         CMD_REMOVE: begin
            for (int i = 0; i < TableEntries; i++)
               if (!hit && table_copy[i].valid && table_copy[i].data.producer == prod &&
                   table_copy[i].data.consumer == cons) begin
                  table_copy[i].valid = 1'b0;
                  hit = 1'b1;
                  outcome_q.push_back('{1'b1, table_copy[i].data.producer,
                     table_copy[i].data.consumer, table_copy[i].data.proc_addr, 1'b1});
               end
            if (!hit) outcome_q.push_back('{1'b0, 16'd0, 16'd0, 16'd0, 1'b1});
         end
         default: begin
            for (int i = 0; i < TableEntries; i++)
               if (table_copy[i].valid && table_copy[i].data.producer == prod) begin
                  table_copy[i].valid = 1'b0;
                  outcome_q.push_back('{1'b1, table_copy[i].data.producer,
                     table_copy[i].data.consumer, table_copy[i].data.proc_addr, 1'b0});
                  n++;
               end
            if (n == 0) outcome_q.push_back('{1'b0, 16'd0, 16'd0, 16'd0, 1'b1});
            else outcome_q[outcome_q.size()-1].last = 1'b1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < TableEntries; i++) table_copy[i].valid = 1'b0;
      end else begin
         if (rsp_valid) begin
            rsp_count++;
            if (outcome_q.size() == 0) begin
               report("result with nothing expected");
            end else begin
               want = outcome_q.pop_front();
               if (rsp_ok !== want.ok)
                  report($sformatf("ok %b, want %b", rsp_ok, want.ok));
               if (rsp_entry_producer !== want.producer)
                  report($sformatf("producer %h, want %h", rsp_entry_producer, want.producer));
               if (rsp_entry_consumer !== want.consumer)
                  report($sformatf("consumer %h, want %h", rsp_entry_consumer, want.consumer));
               if (rsp_entry_proc !== want.proc_addr)
                  report($sformatf("proc %h, want %h", rsp_entry_proc, want.proc_addr));
               if (rsp_last !== want.last)
                  report($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
         if (start && !busy)
            predict_table(cmd_type'(req_cmd), req_producer_task, req_consumer_task,
                          req_requester_proc);
      end
   end
endmodule

// File: tb/sv/testbench.sv
module testbench;
   import mrt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = CMD_INSERT;
   logic [15:0] req_producer_task = '0;
   logic [15:0] req_consumer_task = '0;
   logic [15:0] req_requester_proc = '0;
   logic        rsp_valid, rsp_ok, rsp_last;
   logic [15:0] rsp_entry_producer, rsp_entry_consumer, rsp_entry_proc;
   int          fail_count, pending_count, rsp_count;
   int          idle_pct;
   int          transfer_count = 0;
   logic [15:0] producer_pool[4];
   logic [15:0] consumer_pool[4];

   always #5 clock = ~clock;

   message_request_table dut (.*);

   request_table_checker checker_inst (.*);

   task automatic send(input cmd_type cmd, input logic [15:0] prod,
                       input logic [15:0] cons, input logic [15:0] proc_addr);
      do @(posedge clock); while ($urandom_range(99) < idle_pct);
      start <= 1'b1;
      req_cmd <= cmd;
      req_producer_task <= prod;
      req_consumer_task <= cons;
      req_requester_proc <= proc_addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      transfer_count++;
      start <= 1'b0;
      req_cmd <= cmd_type'($urandom_range(3));
      req_producer_task <= 16'($urandom);
      req_consumer_task <= 16'($urandom);
      req_requester_proc <= 16'($urandom);
   endtask

   task automatic send_random();
      int pick;
      cmd_type cmd;
      logic [15:0] prod, cons;
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_INSERT;
      else if (pick < 60) cmd = CMD_SEARCH;
      else if (pick < 85) cmd = CMD_REMOVE;
      else cmd = CMD_REMOVE_ALL;
      prod = $urandom_range(9) == 0 ? 16'($urandom) : producer_pool[2'($urandom_range(3))];
      cons = $urandom_range(9) == 0 ? 16'($urandom) : consumer_pool[2'($urandom_range(3))];
      send(cmd, prod, cons, 16'($urandom));
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(CMD_SEARCH, 16'h0000, 16'h0000, 16'h0000);
      send(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000);
      send(CMD_REMOVE_ALL, 16'h0000, 16'h0000, 16'h0000);
      for (int i = 0; i < TableEntries; i++)
         send(CMD_INSERT, i[0] ? 16'hFFFF : 16'h0000, 16'(i), i[1] ? 16'hFFFF : 16'(i));
      send(CMD_INSERT, 16'h1234, 16'h5678, 16'h9ABC);
      send(CMD_SEARCH, 16'hFFFF, 16'h0003, 16'h0000);
      send(CMD_SEARCH, 16'h7FFF, 16'h0003, 16'h0000);
      send(CMD_REMOVE, 16'h0000, 16'h0002, 16'h0000);
      send(CMD_REMOVE_ALL, 16'hFFFF, 16'h0000, 16'hFFFF);
      send(CMD_REMOVE_ALL, 16'h0000, 16'hFFFF, 16'h0000);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase == 0 ? 11 : phase == 1 ? 80 : 0;
         for (int k = 0; k < 4; k++) begin
            producer_pool[k] = k == 0 ? 16'h0000 : k == 1 ? 16'hFFFF : 16'($urandom);
            consumer_pool[k] = k == 0 ? 16'hFFFF : k == 1 ? 16'h0000 : 16'($urandom);
         end
         for (int n = 0; n < 120; n++) send_random();
         drain();
      end
      repeat (TableEntries + 8) @(posedge clock);
      $display("covered %0d transfers in, %0d results out, incl. full table and remove-all",
               transfer_count, rsp_count);
      if (fail_count == 0)
         $display("** message_request_table: PASSED **");
      else
         $display("** message_request_table: FAILED **");
      $finish;
   end

   initial begin
      #3000000;
      $display("** message_request_table: FAILED **");
      $finish;
   end
endmodule
